// ----- sv/sad_pkg.sv -----
// Package for the sprite attribute decoder.
// Holds the decoded sprite type, position widths and the position constants.
// No dependencies.
package sad_pkg;

   localparam int unsigned CODE_WIDTH  = 10;
   localparam int unsigned POS_WIDTH   = 10;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned COLOR_WIDTH = 2;
   localparam int unsigned IDX_WIDTH   = 2;

   typedef logic signed [POS_WIDTH-1:0] pos_type;
   typedef logic [IDX_WIDTH-1:0]        idx_type;

   localparam pos_type FLIP_ORIGIN = pos_type'(240);
   localparam pos_type WRAP_OFFSET = pos_type'(256);
   localparam pos_type DOUBLE_STEP = pos_type'(16);

   localparam idx_type IDX_LAST_SINGLE = idx_type'(1);
   localparam idx_type IDX_LAST_DOUBLE = idx_type'(3);

   // Attribute byte bit positions
   localparam int unsigned ATTR_CODE_HI = 7;
   localparam int unsigned ATTR_CODE_LO = 6;
   localparam int unsigned ATTR_DOUBLE  = 4;
   localparam int unsigned ATTR_COLOR_1 = 3;
   localparam int unsigned ATTR_FLIPX   = 2;
   localparam int unsigned ATTR_FLIPY   = 1;
   localparam int unsigned ATTR_COLOR_0 = 0;

   typedef struct packed {
      logic [CODE_WIDTH-1:0]  code;
      logic [COLOR_WIDTH-1:0] color;
      logic                   fx;
      logic                   fy;
      logic                   dbl;
      pos_type                sx;
      pos_type                ye;
      pos_type                yo;
   } sprite_type;

endpackage

// ----- sv/sad_decode.sv -----
// Entry decode stage of the sprite attribute decoder.
// Registers one decoded sprite entry; depends on sad_pkg.
module sad_decode
   import sad_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  screen_flipped,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_WIDTH-1:0] req_pos_y,
   input  logic [BYTE_WIDTH-1:0] req_attributes,
   input  logic [BYTE_WIDTH-1:0] req_pos_x,
   input  logic [BYTE_WIDTH-1:0] req_tile_low,
   output logic                  spr_valid,
   output sprite_type            spr,
   input  logic                  spr_pop
);

   logic       valid_ff, valid_in;
   sprite_type spr_ff, spr_in;
   pos_type    x_ext, y_ext, sy;

   assign req_ready = !valid_ff || spr_pop;

   always_comb begin
      x_ext = pos_type'({{(POS_WIDTH-BYTE_WIDTH){1'b0}}, req_pos_x});
      y_ext = pos_type'({{(POS_WIDTH-BYTE_WIDTH){1'b0}}, req_pos_y});

      spr_in.code  = {req_attributes[ATTR_CODE_HI:ATTR_CODE_LO], req_tile_low};
      spr_in.color = {req_attributes[ATTR_COLOR_1], req_attributes[ATTR_COLOR_0]};
      spr_in.fx    = req_attributes[ATTR_FLIPX] ^ screen_flipped;
      spr_in.fy    = req_attributes[ATTR_FLIPY] ^ screen_flipped;
      spr_in.dbl   = req_attributes[ATTR_DOUBLE];
      spr_in.sx    = screen_flipped ? FLIP_ORIGIN - x_ext : x_ext;
      sy           = screen_flipped ? FLIP_ORIGIN - y_ext : y_ext;
      if (spr_in.dbl && screen_flipped) begin
         sy = sy - DOUBLE_STEP;
      end
      if (spr_in.dbl) begin
         spr_in.ye = spr_in.fy ? sy : sy + DOUBLE_STEP;
         spr_in.yo = spr_in.fy ? sy + DOUBLE_STEP : sy;
      end else begin
         spr_in.ye = sy;
         spr_in.yo = sy;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (spr_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         spr_ff <= spr_in;
      end
   end

   assign spr_valid = valid_ff;
   assign spr       = spr_ff;

endmodule

// ----- sv/sad_emit.sv -----
// Draw command sequencer and result register of the sprite attribute decoder.
// Steps through the two or four commands of a decoded sprite; depends on sad_pkg.
module sad_emit
   import sad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   spr_valid,
   input  sprite_type             spr,
   output logic                   spr_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CODE_WIDTH-1:0]  rsp_tile_code,
   output logic [COLOR_WIDTH-1:0] rsp_palette_sel,
   output logic                   rsp_mirror_x,
   output logic                   rsp_mirror_y,
   output pos_type                rsp_draw_x,
   output pos_type                rsp_draw_y,
   output logic                   rsp_last
);

   idx_type                idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CODE_WIDTH-1:0]  tile_code_ff, tile_code_in;
   pos_type                draw_x_ff, draw_x_in;
   pos_type                draw_y_ff, draw_y_in;
   logic [COLOR_WIDTH-1:0] palette_sel_ff;
   logic                   mirror_x_ff, mirror_y_ff;
   logic                   last_ff, last_in;
   logic                   load;
   logic                   wrap;

   assign load    = !rsp_valid_ff || rsp_ready;
   assign spr_pop = load && spr_valid && last_in;

   always_comb begin
      if (spr.dbl) begin
         tile_code_in = {spr.code[CODE_WIDTH-1:1], idx_ff[0]};
         draw_y_in    = idx_ff[0] ? spr.yo : spr.ye;
         wrap         = idx_ff[1];
         last_in      = (idx_ff == IDX_LAST_DOUBLE);
      end else begin
         tile_code_in = spr.code;
         draw_y_in    = spr.ye;
         wrap         = idx_ff[0];
         last_in      = (idx_ff == IDX_LAST_SINGLE);
      end
      draw_x_in = wrap ? spr.sx - WRAP_OFFSET : spr.sx;
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = spr_valid;
         if (spr_valid) begin
            idx_in = last_in ? '0 : idx_ff + idx_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && spr_valid) begin
         tile_code_ff   <= tile_code_in;
         palette_sel_ff <= spr.color;
         mirror_x_ff    <= spr.fx;
         mirror_y_ff    <= spr.fy;
         draw_x_ff      <= draw_x_in;
         draw_y_ff      <= draw_y_in;
         last_ff        <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_code   = tile_code_ff;
   assign rsp_palette_sel = palette_sel_ff;
   assign rsp_mirror_x    = mirror_x_ff;
   assign rsp_mirror_y    = mirror_y_ff;
   assign rsp_draw_x      = draw_x_ff;
   assign rsp_draw_y      = draw_y_ff;
   assign rsp_last        = last_ff;

   a_idx_needs_sprite: assert property (@(posedge clock) disable iff (reset)
      idx_ff != '0 |-> spr_valid)
      else $error("command index advanced without a sprite held");

   a_single_two_cmds: assert property (@(posedge clock) disable iff (reset)
      spr_valid && !spr.dbl |-> idx_ff == '0 || idx_ff == IDX_LAST_SINGLE)
      else $error("single sprite stepped past its second command");

   a_hold_until_last: assert property (@(posedge clock) disable iff (reset)
      load && spr_valid && !last_in |=> spr_valid && idx_ff != '0)
      else $error("sprite dropped before its last command");

endmodule

// ----- sv/sprite_attribute_decoder_unit.sv -----
// Sprite attribute decoder, top level: screen flip register, entry decode stage
// and draw command sequencer. Depends on sad_pkg, sad_decode and sad_emit.
//
// Each accepted sprite entry yields two draw commands (single width) or four
// (double width), one per cycle on the rsp_ channel while rsp_ready is high; the
// entry is registered in the decode stage and each command in the result
// register. An entry can be accepted in the cycle its predecessor's last command
// is loaded, so a new entry is taken while the last one's final command is still
// in the result register. screen_flipped is written through the csr_ channel,
// which is always ready.
module sprite_attribute_decoder_unit
   import sad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_screen_flipped,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_WIDTH-1:0]  req_pos_y,
   input  logic [BYTE_WIDTH-1:0]  req_attributes,
   input  logic [BYTE_WIDTH-1:0]  req_pos_x,
   input  logic [BYTE_WIDTH-1:0]  req_tile_low,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CODE_WIDTH-1:0]  rsp_tile_code,
   output logic [COLOR_WIDTH-1:0] rsp_palette_sel,
   output logic                   rsp_mirror_x,
   output logic                   rsp_mirror_y,
   output pos_type                rsp_draw_x,
   output pos_type                rsp_draw_y,
   output logic                   rsp_last
);

   logic       screen_flipped_ff, screen_flipped_in;
   logic       spr_valid;
   logic       spr_pop;
   sprite_type spr;

   assign csr_ready         = 1'b1;
   assign screen_flipped_in = (csr_valid && csr_ready) ? csr_screen_flipped
                                                       : screen_flipped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_flipped_ff <= 1'b0;
      end else begin
         screen_flipped_ff <= screen_flipped_in;
      end
   end

   sad_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .screen_flipped (screen_flipped_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pos_y      (req_pos_y),
      .req_attributes (req_attributes),
      .req_pos_x      (req_pos_x),
      .req_tile_low   (req_tile_low),
      .spr_valid      (spr_valid),
      .spr            (spr),
      .spr_pop        (spr_pop)
   );

   sad_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .spr_valid       (spr_valid),
      .spr             (spr),
      .spr_pop         (spr_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tile_code   (rsp_tile_code),
      .rsp_palette_sel (rsp_palette_sel),
      .rsp_mirror_x    (rsp_mirror_x),
      .rsp_mirror_y    (rsp_mirror_y),
      .rsp_draw_x      (rsp_draw_x),
      .rsp_draw_y      (rsp_draw_y),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- test/sprite_attribute_decoder_unit_tb.sv -----
// Testbench for sprite_attribute_decoder_unit: directed table, then random sprite entries.
// Draw commands are checked field by field against typed table values or an in-bench decoder model.
// Depends on sad_pkg and the sprite_attribute_decoder_unit RTL.
`timescale 1ns / 100ps

module sprite_attribute_decoder_unit_tb;
   import sad_pkg::*;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] pos_y;
      logic [BYTE_WIDTH-1:0] attributes;
      logic [BYTE_WIDTH-1:0] pos_x;
      logic [BYTE_WIDTH-1:0] tile_low;
   } entry_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0]  tile_code;
      logic [COLOR_WIDTH-1:0] palette_sel;
      logic                   mirror_x;
      logic                   mirror_y;
      pos_type                draw_x;
      pos_type                draw_y;
      logic                   last;
   } draw_cmd_type;

   typedef struct packed {
      logic         flip;
      entry_type    entry;
      logic         typed;
      draw_cmd_type first;
      draw_cmd_type second;
   } sprite_row_type;

   localparam draw_cmd_type NO_CMD = '0;
   localparam int DIRECTED_ROWS = 19;
   localparam int NUM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 52;
   localparam int HOLD_OFF_CYCLES = 80;

   localparam sprite_row_type SPRITE_ROWS [DIRECTED_ROWS] = '{
      '{1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
        '{10'h000, 2'd0, 1'b0, 1'b0, pos_type'(0), pos_type'(0), 1'b0},
        '{10'h000, 2'd0, 1'b0, 1'b0, pos_type'(-256), pos_type'(0), 1'b1}},
      '{1'b0, '{8'hff, 8'hef, 8'hff, 8'hff}, 1'b1,
        '{10'h3ff, 2'd3, 1'b1, 1'b1, pos_type'(255), pos_type'(255), 1'b0},
        '{10'h3ff, 2'd3, 1'b1, 1'b1, pos_type'(-1), pos_type'(255), 1'b1}},
      '{1'b0, '{8'h10, 8'h10, 8'h20, 8'h35}, 1'b0, NO_CMD, NO_CMD},
      '{1'b0, '{8'h10, 8'h12, 8'h20, 8'h35}, 1'b0, NO_CMD, NO_CMD},
      '{1'b0, '{8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, NO_CMD, NO_CMD},
      '{1'b0, '{8'h00, 8'h10, 8'h00, 8'h00}, 1'b0, NO_CMD, NO_CMD},
      '{1'b0, '{8'h55, 8'h20, 8'haa, 8'h5a}, 1'b0, NO_CMD, NO_CMD},
      '{1'b0, '{8'h33, 8'h24, 8'hcc, 8'h0f}, 1'b0, NO_CMD, NO_CMD},
      '{1'b0, '{8'h80, 8'h42, 8'h40, 8'hf0}, 1'b0, NO_CMD, NO_CMD},
      '{1'b0, '{8'h7f, 8'h89, 8'h80, 8'h01}, 1'b0, NO_CMD, NO_CMD},
      '{1'b0, '{8'hf0, 8'h3a, 8'hf0, 8'hfe}, 1'b0, NO_CMD, NO_CMD},
      '{1'b1, '{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
        '{10'h000, 2'd0, 1'b1, 1'b1, pos_type'(240), pos_type'(240), 1'b0},
        '{10'h000, 2'd0, 1'b1, 1'b1, pos_type'(-16), pos_type'(240), 1'b1}},
      '{1'b1, '{8'hff, 8'h00, 8'hff, 8'h00}, 1'b1,
        '{10'h000, 2'd0, 1'b1, 1'b1, pos_type'(-15), pos_type'(-15), 1'b0},
        '{10'h000, 2'd0, 1'b1, 1'b1, pos_type'(-271), pos_type'(-15), 1'b1}},
      '{1'b1, '{8'hff, 8'h10, 8'h10, 8'h21}, 1'b0, NO_CMD, NO_CMD},
      '{1'b1, '{8'h00, 8'h12, 8'h00, 8'h80}, 1'b0, NO_CMD, NO_CMD},
      '{1'b1, '{8'hf0, 8'h16, 8'hf0, 8'hff}, 1'b0, NO_CMD, NO_CMD},
      '{1'b1, '{8'h01, 8'hef, 8'hf1, 8'h7e}, 1'b0, NO_CMD, NO_CMD},
      '{1'b1, '{8'h80, 8'hd5, 8'h7f, 8'hc3}, 1'b0, NO_CMD, NO_CMD},
      '{1'b1, '{8'h10, 8'hff, 8'hef, 8'hff}, 1'b0, NO_CMD, NO_CMD}
   };

   localparam bit PHASE_FLIP  [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam int PHASE_STALL [NUM_PHASES] = '{0, 30, 60, 0, 20, 45};
   localparam bit PHASE_EAGER [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic                   csr_screen_flipped;
   logic                   req_valid;
   logic                   req_ready;
   logic [BYTE_WIDTH-1:0]  req_pos_y;
   logic [BYTE_WIDTH-1:0]  req_attributes;
   logic [BYTE_WIDTH-1:0]  req_pos_x;
   logic [BYTE_WIDTH-1:0]  req_tile_low;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CODE_WIDTH-1:0]  rsp_tile_code;
   logic [COLOR_WIDTH-1:0] rsp_palette_sel;
   logic                   rsp_mirror_x;
   logic                   rsp_mirror_y;
   pos_type                rsp_draw_x;
   pos_type                rsp_draw_y;
   logic                   rsp_last;

   draw_cmd_type pending_cmds [$];
   bit           flip_setting;
   bit           sender_eager;
   int unsigned  burst_left;
   int unsigned  stall_pct;
   bit           hold_request;
   int unsigned  mismatch_count;
   int unsigned  entries_sent;
   int unsigned  cmds_checked;

   sprite_attribute_decoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_screen_flipped (csr_screen_flipped),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pos_y          (req_pos_y),
      .req_attributes     (req_attributes),
      .req_pos_x          (req_pos_x),
      .req_tile_low       (req_tile_low),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tile_code      (rsp_tile_code),
      .rsp_palette_sel    (rsp_palette_sel),
      .rsp_mirror_x       (rsp_mirror_x),
      .rsp_mirror_y       (rsp_mirror_y),
      .rsp_draw_x         (rsp_draw_x),
      .rsp_draw_y         (rsp_draw_y),
      .rsp_last           (rsp_last)
   );

   always #2 clock = ~clock;

   function automatic void push_draw_cmd(input draw_cmd_type base, input logic [9:0] code,
                                         input pos_type x, input pos_type y, input logic last);
      draw_cmd_type c;
      c = base;
      c.tile_code = code;
      c.draw_x = x;
      c.draw_y = y;
      c.last = last;
      pending_cmds.push_back(c);
   endfunction

   function automatic void decode_sprite(input entry_type e, input bit flipped);
      draw_cmd_type base;
      logic [CODE_WIDTH-1:0] code;
      pos_type sx;
      pos_type sy;
      pos_type y_even;
      pos_type y_odd;
      base = '0;
      code = {e.attributes[ATTR_CODE_HI:ATTR_CODE_LO], e.tile_low};
      base.palette_sel = {e.attributes[ATTR_COLOR_1], e.attributes[ATTR_COLOR_0]};
      base.mirror_x = e.attributes[ATTR_FLIPX] ^ flipped;
      base.mirror_y = e.attributes[ATTR_FLIPY] ^ flipped;
      sx = pos_type'({2'b00, e.pos_x});
      sy = pos_type'({2'b00, e.pos_y});
      if (flipped) begin
         sx = FLIP_ORIGIN - sx;
         sy = FLIP_ORIGIN - sy;
      end
      if (e.attributes[ATTR_DOUBLE]) begin
         if (flipped)
            sy = sy - DOUBLE_STEP;
         y_even = base.mirror_y ? sy : sy + DOUBLE_STEP;
         y_odd  = base.mirror_y ? sy + DOUBLE_STEP : sy;
         push_draw_cmd(base, {code[9:1], 1'b0}, sx, y_even, 1'b0);
         push_draw_cmd(base, {code[9:1], 1'b1}, sx, y_odd, 1'b0);
         push_draw_cmd(base, {code[9:1], 1'b0}, sx - WRAP_OFFSET, y_even, 1'b0);
         push_draw_cmd(base, {code[9:1], 1'b1}, sx - WRAP_OFFSET, y_odd, 1'b1);
      end else begin
         push_draw_cmd(base, code, sx, sy, 1'b0);
         push_draw_cmd(base, code, sx - WRAP_OFFSET, sy, 1'b1);
      end
   endfunction

   function automatic logic [7:0] random_position();
      logic [7:0] edges [6];
      edges = '{8'h00, 8'hff, 8'hf0, 8'h10, 8'h01, 8'hfe};
      if ($urandom_range(0, 7) == 0)
         return edges[$urandom_range(0, 5)];
      return 8'($urandom);
   endfunction

   function automatic entry_type random_entry();
      entry_type e;
      e.pos_y = random_position();
      e.attributes = 8'($urandom);
      e.pos_x = random_position();
      e.tile_low = 8'($urandom);
      return e;
   endfunction

   // hold the entry until the block takes it
   task automatic offer(input entry_type e);
      req_valid <= 1'b1;
      req_pos_y <= e.pos_y;
      req_attributes <= e.attributes;
      req_pos_x <= e.pos_x;
      req_tile_low <= e.tile_low;
      do @(posedge clock); while (!req_ready);
      entries_sent++;
   endtask

   task automatic pace();
      int unsigned gap;
      @(negedge clock);
      if (!sender_eager) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(0, 10);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_flip(input bit value);
      csr_valid <= 1'b1;
      csr_screen_flipped <= value;
      do @(posedge clock); while (!csr_ready);
      flip_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // output side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(1, 100) > stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_draw_cmd
      draw_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected draw command: tile_code %0d draw_x %0d draw_y %0d",
                   rsp_tile_code, rsp_draw_x, rsp_draw_y);
            mismatch_count++;
         end else begin
            want = pending_cmds.pop_front();
            cmds_checked++;
            if (rsp_tile_code !== want.tile_code) begin
               $error("tile_code: expected %0d, got %0d", want.tile_code, rsp_tile_code);
               mismatch_count++;
            end
            if (rsp_palette_sel !== want.palette_sel) begin
               $error("palette_sel: expected %0d, got %0d", want.palette_sel, rsp_palette_sel);
               mismatch_count++;
            end
            if (rsp_mirror_x !== want.mirror_x) begin
               $error("mirror_x: expected %0d, got %0d", want.mirror_x, rsp_mirror_x);
               mismatch_count++;
            end
            if (rsp_mirror_y !== want.mirror_y) begin
               $error("mirror_y: expected %0d, got %0d", want.mirror_y, rsp_mirror_y);
               mismatch_count++;
            end
            if (rsp_draw_x !== want.draw_x) begin
               $error("draw_x: expected %0d, got %0d", want.draw_x, rsp_draw_x);
               mismatch_count++;
            end
            if (rsp_draw_y !== want.draw_y) begin
               $error("draw_y: expected %0d, got %0d", want.draw_y, rsp_draw_y);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_screen_flipped = 1'b0;
      req_valid = 1'b0;
      req_pos_y = '0;
      req_attributes = '0;
      req_pos_x = '0;
      req_tile_low = '0;
      flip_setting = 1'b0;
      sender_eager = 1'b0;
      burst_left = 0;
      stall_pct = 25;
      hold_request = 1'b0;
      mismatch_count = 0;
      entries_sent = 0;
      cmds_checked = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_flip(1'b0);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (SPRITE_ROWS[i].flip != flip_setting) begin
            drain();
            write_flip(SPRITE_ROWS[i].flip);
         end
         offer(SPRITE_ROWS[i].entry);
         if (SPRITE_ROWS[i].typed) begin
            pending_cmds.push_back(SPRITE_ROWS[i].first);
            pending_cmds.push_back(SPRITE_ROWS[i].second);
         end else begin
            decode_sprite(SPRITE_ROWS[i].entry, flip_setting);
         end
         pace();
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_flip(PHASE_FLIP[p]);
         stall_pct = PHASE_STALL[p];
         sender_eager = PHASE_EAGER[p];
         if (p == 1)
            hold_request = 1'b1;
         for (int j = 0; j < ITEMS_PER_PHASE; j++) begin : random_item
            entry_type e;
            e = random_entry();
            offer(e);
            decode_sprite(e, flip_setting);
            pace();
         end
      end

      drain();
      repeat (8) @(negedge clock);
      $display("Covered %0d sprite entries and %0d draw commands, single and double width,",
               entries_sent, cmds_checked);
      $display("both screen flip settings, output stalls and one long output hold-off.");
      if (mismatch_count == 0 && pending_cmds.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
